/* rtl/swhf_pkg.sv */
// Shared types, sizes and saturating Q-format arithmetic for the HLL flux core.
// No dependencies; used by every module of the block.
`default_nettype none

package swhf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Stream payload sizes
    localparam int IN_FIELDS = 6;
    localparam int IN_BITS   = IN_FIELDS * WORD_BITS;
    localparam int OUT_USED  = 4 * WORD_BITS - 1;
    localparam int OUT_BITS  = ((OUT_USED + 7) / 8) * 8;

    // Register map
    localparam int         ADDR_BITS    = 2;
    localparam logic [1:0] ADDR_GRAVITY = 2'd0;
    localparam logic [WORD_BITS-2:0] GRAVITY_RESET = (WORD_BITS - 1)'(642908);

    // Square root: floor(sqrt(x * 2^F)) for a nonnegative (W-1)-bit x
    localparam int SQRT_BITS   = (WORD_BITS - 1 + FRAC_BITS + 1) / 2;
    localparam int SQRT_STEP   = 4;
    localparam int SQRT_STAGES = (SQRT_BITS + SQRT_STEP - 1) / SQRT_STEP;

    // Divider: (|a| * 2^F) / |b|, one quotient bit per step
    localparam int DIV_BITS   = WORD_BITS + FRAC_BITS;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEP - 1) / DIV_STEP;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        umag_t;

    typedef struct packed {
        word_t val;
        logic  clip;
    } sres_t;

    localparam logic [2*WORD_BITS-1:0] POS_LIM =
        {{(WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic [2*WORD_BITS-1:0] NEG_LIM = POS_LIM + 1'b1;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    function automatic umag_t mag(input word_t a);
        return a[WORD_BITS-1] ? umag_t'(~a + 1'b1) : umag_t'(a);
    endfunction

    function automatic sres_t from_mag(input logic [2*WORD_BITS-1:0] m, input logic neg);
        sres_t                  r;
        logic [2*WORD_BITS-1:0] lim;
        logic [2*WORD_BITS-1:0] mm;
        lim = neg ? NEG_LIM : POS_LIM;
        r.clip = (m > lim);
        mm = r.clip ? lim : m;
        r.val = neg ? word_t'(~mm[WORD_BITS-1:0] + 1'b1) : word_t'(mm[WORD_BITS-1:0]);
        return r;
    endfunction

    // Exact product, magnitude shifted right (truncation toward zero), saturated
    function automatic sres_t fx_mul(input word_t a, input word_t b);
        logic [2*WORD_BITS-1:0] p;
        p = {{WORD_BITS{1'b0}}, mag(a)} * {{WORD_BITS{1'b0}}, mag(b)};
        return from_mag(p >> FRAC_BITS, a[WORD_BITS-1] ^ b[WORD_BITS-1]);
    endfunction

    function automatic sres_t fx_add(input word_t a, input word_t b);
        sres_t                r;
        logic [WORD_BITS:0]   s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
        r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
        return r;
    endfunction

    function automatic sres_t fx_sub(input word_t a, input word_t b);
        sres_t                r;
        logic [WORD_BITS:0]   s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
        r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
        return r;
    endfunction

    function automatic sres_t fx_abs(input word_t a);
        sres_t r;
        if (a[WORD_BITS-1])
        begin
            r = fx_sub('0, a);
        end
        else
        begin
            r.val  = a;
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Product with one half; never clips
    function automatic word_t fx_half(input word_t a);
        umag_t m;
        m = mag(a) >> 1;
        return a[WORD_BITS-1] ? word_t'(~m + 1'b1) : word_t'(m);
    endfunction

endpackage

`default_nettype wire

/* rtl/shallow_water_hll_flux_core.sv */
// HLL flux core: one face per cycle while no result is stalled.
// Pipeline: 4 front stages + SQRT_STAGES (6) + 4 flux stages + DIV_STAGES (12) + output reg.
// Throughput: one transaction per cycle; the whole pipe holds while a result is stalled.
// The divider pipeline (one quotient bit per step, 48 steps) sets the depth.
// rst_n clears valid bits and restores gravity to 9.81; no other state.
// Depends on swhf_pkg, swhf_cfg, swhf_sqrt and swhf_div.
`default_nettype none

module shallow_water_hll_flux_core (
    input  wire                               clk,
    input  wire                               rst_n,
    // s_tdata: left_depth, left_vel_x, left_vel_y, right_depth, right_vel_x, right_vel_y
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [swhf_pkg::IN_BITS-1:0]      s_tdata,
    // m_tdata: mass_flux, normal_momentum_flux, tangent_momentum_flux, max_wave_speed
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [swhf_pkg::OUT_BITS-1:0]     m_tdata,
    // m_tuser: saturated
    output logic                              m_tuser,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [swhf_pkg::ADDR_BITS-1:0]    paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int W   = swhf_pkg::WORD_BITS;
    localparam int SQS = swhf_pkg::SQRT_STAGES;
    localparam int DVS = swhf_pkg::DIV_STAGES;

    typedef enum logic [2:0] {K_DRY, K_ZERO, K_LEFT, K_RIGHT, K_BLEND} kind_t;

    typedef struct packed {
        swhf_pkg::word_t hl, ul, vl, hr, ur, vr;
        swhf_pkg::word_t ghl, ghr, ql, qr, hvl, hvr;
        swhf_pkg::word_t qul, qur, ghhl, ghhr, qvl, qvr, f1l, f1r;
        swhf_pkg::word_t du0, du1, du2;
        swhf_pkg::word_t c1, c2, cc, den, abs1, abs2;
        swhf_pkg::word_t [2:0] m1;
        swhf_pkg::word_t [2:0] m2;
        swhf_pkg::word_t [2:0] cd;
        swhf_pkg::word_t [2:0] num;
        kind_t kind;
        logic  dry;
        logic  fbase, fleft, fright, fblend, fabs1;
    } item_t;

    logic [W-2:0] gravity;
    logic         en;

    item_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    item_t a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    item_t sq_dly_reg [SQS];
    item_t dv_dly_reg [DVS];
    logic  a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic  e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg;
    logic  [SQS-1:0] sq_vld_reg;
    logic  [DVS-1:0] dv_vld_reg;
    logic  m_tvalid_reg;
    logic  [swhf_pkg::OUT_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic  m_tuser_reg, m_tuser_next;

    logic [swhf_pkg::SQRT_BITS-1:0] root_l, root_r;
    swhf_pkg::sres_t                quo [3];

    swhf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gravity (gravity)
    );

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Stage A: capture the transaction
    always_comb
    begin
        a_next    = '0;
        a_next.hl = s_tdata[0*W +: W];
        a_next.ul = s_tdata[1*W +: W];
        a_next.vl = s_tdata[2*W +: W];
        a_next.hr = s_tdata[3*W +: W];
        a_next.ur = s_tdata[4*W +: W];
        a_next.vr = s_tdata[5*W +: W];
    end

    // Stage B: g*h, discharges, h*v
    always_comb
    begin
        swhf_pkg::sres_t ghl, ghr, ql, qr, hvl, hvr;
        ghl = swhf_pkg::fx_mul({1'b0, gravity}, a_reg.hl);
        ghr = swhf_pkg::fx_mul({1'b0, gravity}, a_reg.hr);
        ql  = swhf_pkg::fx_mul(a_reg.ul, a_reg.hl);
        qr  = swhf_pkg::fx_mul(a_reg.ur, a_reg.hr);
        hvl = swhf_pkg::fx_mul(a_reg.hl, a_reg.vl);
        hvr = swhf_pkg::fx_mul(a_reg.hr, a_reg.vr);
        b_next        = a_reg;
        b_next.dry    = !(a_reg.hl > 0 || a_reg.hr > 0);
        b_next.ghl    = ghl.val;
        b_next.ghr    = ghr.val;
        b_next.ql     = ql.val;
        b_next.qr     = qr.val;
        b_next.hvl    = hvl.val;
        b_next.hvr    = hvr.val;
        b_next.fbase  = ghl.clip | ghr.clip;
        b_next.fleft  = ql.clip;
        b_next.fright = qr.clip;
        b_next.fblend = hvl.clip | hvr.clip;
    end

    // Stage C: second-level side products and state jumps
    always_comb
    begin
        swhf_pkg::sres_t qul, qur, ghhl, ghhr, qvl, qvr, du0, du1, du2;
        qul  = swhf_pkg::fx_mul(b_reg.ql, b_reg.ul);
        qur  = swhf_pkg::fx_mul(b_reg.qr, b_reg.ur);
        ghhl = swhf_pkg::fx_mul(b_reg.ghl, b_reg.hl);
        ghhr = swhf_pkg::fx_mul(b_reg.ghr, b_reg.hr);
        qvl  = swhf_pkg::fx_mul(b_reg.ql, b_reg.vl);
        qvr  = swhf_pkg::fx_mul(b_reg.qr, b_reg.vr);
        du0  = swhf_pkg::fx_sub(b_reg.hr, b_reg.hl);
        du1  = swhf_pkg::fx_sub(b_reg.qr, b_reg.ql);
        du2  = swhf_pkg::fx_sub(b_reg.hvr, b_reg.hvl);
        c_next        = b_reg;
        c_next.qul    = qul.val;
        c_next.qur    = qur.val;
        c_next.ghhl   = ghhl.val;
        c_next.ghhr   = ghhr.val;
        c_next.qvl    = qvl.val;
        c_next.qvr    = qvr.val;
        c_next.du0    = du0.val;
        c_next.du1    = du1.val;
        c_next.du2    = du2.val;
        c_next.fleft  = b_reg.fleft | qul.clip | ghhl.clip | qvl.clip;
        c_next.fright = b_reg.fright | qur.clip | ghhr.clip | qvr.clip;
        c_next.fblend = b_reg.fblend | du0.clip | du1.clip | du2.clip;
    end

    // Stage D: momentum flux q*u + g*h*h/2
    always_comb
    begin
        swhf_pkg::sres_t f1l, f1r;
        f1l = swhf_pkg::fx_add(c_reg.qul, swhf_pkg::fx_half(c_reg.ghhl));
        f1r = swhf_pkg::fx_add(c_reg.qur, swhf_pkg::fx_half(c_reg.ghhr));
        d_next        = c_reg;
        d_next.f1l    = f1l.val;
        d_next.f1r    = f1r.val;
        d_next.fleft  = c_reg.fleft | f1l.clip;
        d_next.fright = c_reg.fright | f1r.clip;
    end

    // Negative g*h goes in as zero
    swhf_sqrt u_sqrt_l (
        .clk  (clk),
        .en   (en),
        .x    (d_reg.ghl[W-1] ? '0 : d_reg.ghl[W-2:0]),
        .root (root_l)
    );

    swhf_sqrt u_sqrt_r (
        .clk  (clk),
        .en   (en),
        .x    (d_reg.ghr[W-1] ? '0 : d_reg.ghr[W-2:0]),
        .root (root_r)
    );

    // Stage E: wave speeds and case decode
    always_comb
    begin
        swhf_pkg::word_t sl, sr;
        swhf_pkg::sres_t sa, sb, aa, ab;
        sl = {{(W - swhf_pkg::SQRT_BITS){1'b0}}, root_l};
        sr = {{(W - swhf_pkg::SQRT_BITS){1'b0}}, root_r};
        e_next = sq_dly_reg[SQS-1];
        sa = swhf_pkg::fx_sub(e_next.ul, sl);
        sb = swhf_pkg::fx_sub(e_next.ur, sr);
        aa = swhf_pkg::fx_add(e_next.ul, sl);
        ab = swhf_pkg::fx_add(e_next.ur, sr);
        e_next.c1    = (sa.val < sb.val) ? sa.val : sb.val;
        e_next.c2    = (aa.val > ab.val) ? aa.val : ab.val;
        e_next.fbase = e_next.fbase | sa.clip | sb.clip | aa.clip | ab.clip;
        if (e_next.dry)
        begin
            e_next.kind = K_DRY;
        end
        else if (e_next.c1 == 0 && e_next.c2 == 0)
        begin
            e_next.kind = K_ZERO;
        end
        else if (e_next.c1 >= 0)
        begin
            e_next.kind = K_LEFT;
        end
        else if (e_next.c2 <= 0)
        begin
            e_next.kind = K_RIGHT;
        end
        else
        begin
            e_next.kind = K_BLEND;
        end
    end

    // Stage F: speed products for the blend
    always_comb
    begin
        swhf_pkg::sres_t cc, den, a1, a2, m20, m21, m22, m10, m11, m12;
        cc  = swhf_pkg::fx_mul(e_reg.c1, e_reg.c2);
        den = swhf_pkg::fx_sub(e_reg.c2, e_reg.c1);
        a1  = swhf_pkg::fx_abs(e_reg.c1);
        a2  = swhf_pkg::fx_abs(e_reg.c2);
        m20 = swhf_pkg::fx_mul(e_reg.c2, e_reg.ql);
        m21 = swhf_pkg::fx_mul(e_reg.c2, e_reg.f1l);
        m22 = swhf_pkg::fx_mul(e_reg.c2, e_reg.qvl);
        m10 = swhf_pkg::fx_mul(e_reg.c1, e_reg.qr);
        m11 = swhf_pkg::fx_mul(e_reg.c1, e_reg.f1r);
        m12 = swhf_pkg::fx_mul(e_reg.c1, e_reg.qvr);
        f_next       = e_reg;
        f_next.cc    = cc.val;
        f_next.den   = den.val;
        f_next.abs1  = a1.val;
        f_next.abs2  = a2.val;
        f_next.m2[0] = m20.val;
        f_next.m2[1] = m21.val;
        f_next.m2[2] = m22.val;
        f_next.m1[0] = m10.val;
        f_next.m1[1] = m11.val;
        f_next.m1[2] = m12.val;
        f_next.fabs1 = a1.clip;
        f_next.fblend = e_reg.fblend | cc.clip | den.clip | a2.clip | m20.clip | m21.clip
                      | m22.clip | m10.clip | m11.clip | m12.clip;
    end

    // Stage G: c1*c2*dU and c2*FL - c1*FR
    always_comb
    begin
        swhf_pkg::sres_t cd, n0;
        logic            fl;
        swhf_pkg::word_t du;
        g_next = f_reg;
        fl     = f_reg.fblend;
        for (int j = 0; j < 3; j++)
        begin
            du = (j == 0) ? f_reg.du0 : ((j == 1) ? f_reg.du1 : f_reg.du2);
            cd = swhf_pkg::fx_mul(f_reg.cc, du);
            n0 = swhf_pkg::fx_sub(f_reg.m2[j], f_reg.m1[j]);
            g_next.cd[j]  = cd.val;
            g_next.num[j] = n0.val;
            fl = fl | cd.clip | n0.clip;
        end
        g_next.fblend = fl;
    end

    // Stage H: numerators
    always_comb
    begin
        swhf_pkg::sres_t s;
        logic            fl;
        h_next = g_reg;
        fl     = g_reg.fblend;
        for (int j = 0; j < 3; j++)
        begin
            s = swhf_pkg::fx_add(g_reg.num[j], g_reg.cd[j]);
            h_next.num[j] = s.val;
            fl = fl | s.clip;
        end
        h_next.fblend = fl;
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_div
        swhf_div u_div (
            .clk (clk),
            .en  (en),
            .num (h_reg.num[j]),
            .den (h_reg.den),
            .quo (quo[j])
        );
    end

    // Output stage: pick the case
    always_comb
    begin
        item_t           it;
        swhf_pkg::word_t f0, f1, f2, spd;
        logic            sat;
        it  = dv_dly_reg[DVS-1];
        f0  = '0;
        f1  = '0;
        f2  = '0;
        spd = '0;
        sat = 1'b0;
        case (it.kind)
            K_ZERO:
            begin
                sat = it.fbase;
            end
            K_LEFT:
            begin
                f0  = it.ql;
                f1  = it.f1l;
                f2  = it.qvl;
                spd = it.c2;
                sat = it.fbase | it.fleft;
            end
            K_RIGHT:
            begin
                f0  = it.qr;
                f1  = it.f1r;
                f2  = it.qvr;
                spd = it.abs1;
                sat = it.fbase | it.fright | it.fabs1;
            end
            K_BLEND:
            begin
                f0  = quo[0].val;
                f1  = quo[1].val;
                f2  = quo[2].val;
                spd = (it.abs1 > it.abs2) ? it.abs1 : it.abs2;
                sat = it.fbase | it.fleft | it.fright | it.fabs1 | it.fblend
                    | quo[0].clip | quo[1].clip | quo[2].clip;
            end
            default:
            begin
                sat = 1'b0;
            end
        endcase
        m_tdata_next = swhf_pkg::OUT_BITS'({spd[W-2:0], f2, f1, f0});
        m_tuser_next = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d_vld_reg    <= 1'b0;
            sq_vld_reg   <= '0;
            e_vld_reg    <= 1'b0;
            f_vld_reg    <= 1'b0;
            g_vld_reg    <= 1'b0;
            h_vld_reg    <= 1'b0;
            dv_vld_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg    <= s_tvalid;
            b_vld_reg    <= a_vld_reg;
            c_vld_reg    <= b_vld_reg;
            d_vld_reg    <= c_vld_reg;
            sq_vld_reg   <= {sq_vld_reg[SQS-2:0], d_vld_reg};
            e_vld_reg    <= sq_vld_reg[SQS-1];
            f_vld_reg    <= e_vld_reg;
            g_vld_reg    <= f_vld_reg;
            h_vld_reg    <= g_vld_reg;
            dv_vld_reg   <= {dv_vld_reg[DVS-2:0], h_vld_reg};
            m_tvalid_reg <= dv_vld_reg[DVS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            sq_dly_reg[0] <= d_reg;
            for (int i = 1; i < SQS; i++)
            begin
                sq_dly_reg[i] <= sq_dly_reg[i-1];
            end
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            dv_dly_reg[0] <= h_reg;
            for (int i = 1; i < DVS; i++)
            begin
                dv_dly_reg[i] <= dv_dly_reg[i-1];
            end
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A stalled result holds the whole pipe
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // An accepted transaction enters stage A
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> a_vld_reg)
        else $error("accepted transaction lost");

    // Blend case only with opposite-sign wave speeds
    a_blend_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        (e_vld_reg && e_reg.kind == K_BLEND) |-> (e_reg.c1 < 0 && e_reg.c2 > 0))
        else $error("blend decoded with same-sign speeds");

    // Divisor is positive whenever the blend is used
    a_blend_den: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld_reg && f_reg.kind == K_BLEND) |-> (f_reg.den > 0))
        else $error("blend divisor not positive");

endmodule

`default_nettype wire

/* rtl/swhf_cfg.sv */
// APB register block holding the gravity register.
// Depends on swhf_pkg for widths, address map and reset value.
`default_nettype none

module swhf_cfg (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [swhf_pkg::ADDR_BITS-1:0]   paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [swhf_pkg::WORD_BITS-2:0]   gravity
);

    logic [swhf_pkg::WORD_BITS-2:0] gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= swhf_pkg::GRAVITY_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == swhf_pkg::ADDR_GRAVITY)
        begin
            gravity_reg <= pwdata[swhf_pkg::WORD_BITS-2:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == swhf_pkg::ADDR_GRAVITY)
        begin
            prdata = 32'(gravity_reg);
        end
    end

    assign pready  = 1'b1;
    assign gravity = gravity_reg;

endmodule

`default_nettype wire

/* rtl/swhf_sqrt.sv */
// Pipelined restoring square root, floor(sqrt(x * 2^FRAC_BITS)).
// Depends on swhf_pkg; SQRT_STEP root bits per stage, SQRT_STAGES stages.
`default_nettype none

module swhf_sqrt (
    input  wire                               clk,
    input  wire                               en,
    input  wire  [swhf_pkg::WORD_BITS-2:0]    x,
    output logic [swhf_pkg::SQRT_BITS-1:0]    root
);

    localparam int RW = swhf_pkg::SQRT_STEP * swhf_pkg::SQRT_STAGES;
    localparam int NS = swhf_pkg::SQRT_STAGES;

    logic [RW+2:0]   rem_reg  [NS];
    logic [RW-1:0]   q_reg    [NS];
    logic [2*RW-1:0] n_reg    [NS];
    logic [RW+2:0]   rem_next [NS];
    logic [RW-1:0]   q_next   [NS];
    logic [2*RW-1:0] n_next   [NS];

    always_comb
    begin
        logic [RW+2:0]   r;
        logic [RW+2:0]   t;
        logic [RW+2:0]   tr;
        logic [RW-1:0]   q;
        logic [2*RW-1:0] n;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                q = '0;
                n = (2*RW)'({x, {swhf_pkg::FRAC_BITS{1'b0}}});
            end
            else
            begin
                r = rem_reg[s-1];
                q = q_reg[s-1];
                n = n_reg[s-1];
            end
            for (int k = 0; k < swhf_pkg::SQRT_STEP; k++)
            begin
                t  = {r[RW:0], n[2*RW-1 -: 2]};
                tr = {1'b0, q, 2'b01};
                if (t >= tr)
                begin
                    r = t - tr;
                    q = {q[RW-2:0], 1'b1};
                end
                else
                begin
                    r = t;
                    q = {q[RW-2:0], 1'b0};
                end
                n = {n[2*RW-3:0], 2'b00};
            end
            rem_next[s] = r;
            q_next[s]   = q;
            n_next[s]   = n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                n_reg[s]   <= n_next[s];
            end
        end
    end

    assign root = q_reg[NS-1][swhf_pkg::SQRT_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/swhf_div.sv */
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// Depends on swhf_pkg; DIV_STEP quotient bits per stage, DIV_STAGES stages.
`default_nettype none

module swhf_div (
    input  wire                    clk,
    input  wire                    en,
    input  wire  swhf_pkg::word_t  num,
    input  wire  swhf_pkg::word_t  den,
    output swhf_pkg::sres_t        quo
);

    localparam int W  = swhf_pkg::WORD_BITS;
    localparam int QW = swhf_pkg::DIV_STEP * swhf_pkg::DIV_STAGES;
    localparam int NS = swhf_pkg::DIV_STAGES;

    logic [W-1:0]  r_reg   [NS];
    logic [QW-1:0] nq_reg  [NS];
    logic [W-1:0]  d_reg   [NS];
    logic          neg_reg [NS];
    logic [W-1:0]  r_next  [NS];
    logic [QW-1:0] nq_next [NS];
    logic [W-1:0]  d_next  [NS];
    logic          neg_next[NS];

    always_comb
    begin
        logic [W-1:0]  r;
        logic [W:0]    t;
        logic [QW-1:0] nq;
        logic [W-1:0]  d;
        logic          ng;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                r  = '0;
                nq = QW'({swhf_pkg::mag(num), {swhf_pkg::FRAC_BITS{1'b0}}});
                d  = swhf_pkg::mag(den);
                ng = num[W-1] ^ den[W-1];
            end
            else
            begin
                r  = r_reg[s-1];
                nq = nq_reg[s-1];
                d  = d_reg[s-1];
                ng = neg_reg[s-1];
            end
            for (int k = 0; k < swhf_pkg::DIV_STEP; k++)
            begin
                t = {r, nq[QW-1]};
                if (t >= {1'b0, d})
                begin
                    t  = t - {1'b0, d};
                    nq = {nq[QW-2:0], 1'b1};
                end
                else
                begin
                    nq = {nq[QW-2:0], 1'b0};
                end
                r = t[W-1:0];
            end
            r_next[s]   = r;
            nq_next[s]  = nq;
            d_next[s]   = d;
            neg_next[s] = ng;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                r_reg[s]   <= r_next[s];
                nq_reg[s]  <= nq_next[s];
                d_reg[s]   <= d_next[s];
                neg_reg[s] <= neg_next[s];
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        m   = '0;
        lim = neg_reg[NS-1] ? QW'(swhf_pkg::NEG_LIM) : QW'(swhf_pkg::POS_LIM);
        if (d_reg[NS-1] == '0)
        begin
            quo.val  = '0;
            quo.clip = 1'b0;
        end
        else
        begin
            quo.clip = nq_reg[NS-1] > lim;
            m = quo.clip ? lim : nq_reg[NS-1];
            quo.val = neg_reg[NS-1] ? swhf_pkg::word_t'(~m[W-1:0] + 1'b1)
                                    : swhf_pkg::word_t'(m[W-1:0]);
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_shallow_water_hll_flux_core.sv */
// Testbench for shallow_water_hll_flux_core: directed and random face items are streamed
// through the core under several gravity settings, and each flux result is checked against a
// bit-accurate fixed-point predictor. Depends on swhf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_shallow_water_hll_flux_core;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [31:0] GRAV_ONE = 32'd65536;
    localparam logic [31:0] GRAV_MAX = 32'h7FFF_FFFF;

    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic [31:0] right_vel_y;
        logic [31:0] right_vel_x;
        logic [31:0] right_depth;
        logic [31:0] left_vel_y;
        logic [31:0] left_vel_x;
        logic [31:0] left_depth;
    } face_t;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] normal_mom;
        logic [31:0] tangent_mom;
        logic [30:0] speed;
        logic        sat;
    } flux_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [swhf_pkg::IN_BITS-1:0]   s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [swhf_pkg::OUT_BITS-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [swhf_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    face_t       pending_faces[$];
    flux_t       expected_fluxes[$];
    logic [30:0] gravity_q = 31'(642908);
    int          cycle_count = 0;
    int          errors = 0;
    int          faces_sent = 0;
    int          fluxes_checked = 0;
    bit          in_fire = 1'b0;

    shallow_water_hll_flux_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // ---------------- fixed-point predictor ----------------
    function automatic wide_t sat_mag(input logic [127:0] m, input bit neg, inout bit clip);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (m > lim)
        begin
            clip = 1'b1;
            m = lim;
        end
        return neg ? -wide_t'(m[63:0]) : wide_t'(m[63:0]);
    endfunction

    function automatic logic [63:0] abs_w(input wide_t a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic wide_t q_add(input wide_t a, input wide_t b, inout bit clip);
        wide_t s;
        s = a + b;
        return sat_mag(abs_w(s), s < 0, clip);
    endfunction

    function automatic wide_t q_sub(input wide_t a, input wide_t b, inout bit clip);
        wide_t s;
        s = a - b;
        return sat_mag(abs_w(s), s < 0, clip);
    endfunction

    function automatic wide_t q_abs(input wide_t a, inout bit clip);
        return a < 0 ? q_sub(0, a, clip) : a;
    endfunction

    function automatic wide_t q_mul(input wide_t a, input wide_t b, inout bit clip);
        logic [127:0] p;
        p = {64'd0, abs_w(a)} * {64'd0, abs_w(b)};
        return sat_mag(p >> swhf_pkg::FRAC_BITS, (a < 0) != (b < 0), clip);
    endfunction

    function automatic wide_t q_div(input wide_t a, input wide_t b, inout bit clip);
        logic [127:0] n;
        if (b == 0)
            return 0;
        n = {64'd0, abs_w(a)} << swhf_pkg::FRAC_BITS;
        return sat_mag(n / {64'd0, abs_w(b)}, (a < 0) != (b < 0), clip);
    endfunction

    function automatic wide_t q_sqrt(input wide_t x, inout bit clip);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] c;
        if (x <= 0)
            return 0;
        n = 64'(x) << swhf_pkg::FRAC_BITS;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            c = r | (64'd1 << k);
            if (c * c <= n)
                r = c;
        end
        return sat_mag({64'd0, r}, 1'b0, clip);
    endfunction

    function automatic void side_flux(input wide_t h, input wide_t u, input wide_t v,
                                      input wide_t gh, output wide_t f[3], inout bit clip);
        wide_t q;
        q = q_mul(u, h, clip);
        f[0] = q;
        f[1] = q_add(q_mul(q, u, clip),
                     q_mul(q_mul(gh, h, clip), wide_t'(1 << (swhf_pkg::FRAC_BITS - 1)), clip),
                     clip);
        f[2] = q_mul(q, v, clip);
    endfunction

    function automatic flux_t hll_flux(input face_t fc, input logic [30:0] grav);
        flux_t r;
        bit    clip;
        wide_t hl, ul, vl, hr, ur, vr, g, ghl, ghr, sl, sr, c1, c2, a, b;
        wide_t cc, den, num, a1, a2, cfl;
        wide_t f[3], fl[3], fr[3], du[3];
        clip = 1'b0;
        hl = wide_t'($signed(fc.left_depth));
        ul = wide_t'($signed(fc.left_vel_x));
        vl = wide_t'($signed(fc.left_vel_y));
        hr = wide_t'($signed(fc.right_depth));
        ur = wide_t'($signed(fc.right_vel_x));
        vr = wide_t'($signed(fc.right_vel_y));
        g = wide_t'({33'd0, grav});
        f[0] = 0;
        f[1] = 0;
        f[2] = 0;
        cfl = 0;
        if (hl > 0 || hr > 0)
        begin
            ghl = q_mul(g, hl, clip);
            ghr = q_mul(g, hr, clip);
            sl = q_sqrt(ghl, clip);
            sr = q_sqrt(ghr, clip);
            a = q_sub(ul, sl, clip);
            b = q_sub(ur, sr, clip);
            c1 = a < b ? a : b;
            a = q_add(ul, sl, clip);
            b = q_add(ur, sr, clip);
            c2 = a > b ? a : b;
            if (c1 == 0 && c2 == 0)
            begin
                cfl = 0;
            end
            else if (c1 >= 0)
            begin
                side_flux(hl, ul, vl, ghl, f, clip);
                cfl = c2;
            end
            else if (c2 <= 0)
            begin
                side_flux(hr, ur, vr, ghr, f, clip);
                cfl = q_abs(c1, clip);
            end
            else
            begin
                side_flux(hl, ul, vl, ghl, fl, clip);
                side_flux(hr, ur, vr, ghr, fr, clip);
                du[0] = q_sub(hr, hl, clip);
                du[1] = q_sub(fr[0], fl[0], clip);
                du[2] = q_sub(q_mul(hr, vr, clip), q_mul(hl, vl, clip), clip);
                cc = q_mul(c1, c2, clip);
                den = q_sub(c2, c1, clip);
                for (int j = 0; j < 3; j++)
                begin
                    num = q_sub(q_mul(c2, fl[j], clip), q_mul(c1, fr[j], clip), clip);
                    num = q_add(num, q_mul(cc, du[j], clip), clip);
                    f[j] = q_div(num, den, clip);
                end
                a1 = q_abs(c1, clip);
                a2 = q_abs(c2, clip);
                cfl = a1 > a2 ? a1 : a2;
            end
        end
        r.mass = f[0][31:0];
        r.normal_mom = f[1][31:0];
        r.tangent_mom = f[2][31:0];
        r.speed = cfl[30:0];
        r.sat = clip;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic face_t make_face(input int ld, input int lu, input int lv,
                                        input int rd, input int ru, input int rv);
        face_t fc;
        fc.left_depth = ld;
        fc.left_vel_x = lu;
        fc.left_vel_y = lv;
        fc.right_depth = rd;
        fc.right_vel_x = ru;
        fc.right_vel_y = rv;
        return fc;
    endfunction

    function automatic logic [31:0] rand_depth();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 32'd0;
        else if (sel < 15)
            return -$urandom_range(1, 32'h0004_0000);
        else
            return $urandom_range(1, 32'h000A_0000);
    endfunction

    function automatic logic [31:0] rand_vel();
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    function automatic face_t rand_face();
        int    sel;
        face_t fc;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            fc = make_face(rand_depth(), rand_vel(), rand_vel(),
                           rand_depth(), rand_vel(), rand_vel());
        end
        else if (sel < 85)
        begin
            // larger magnitudes to reach clipping inside the flux terms
            fc = make_face($urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0400_0000)
                           - 32'h0200_0000, $urandom, rand_depth(),
                           $urandom_range(0, 32'h0400_0000) - 32'h0200_0000, $urandom);
        end
        else
        begin
            fc = make_face($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        return fc;
    endfunction

    task automatic write_gravity(input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= swhf_pkg::ADDR_GRAVITY;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gravity_q = value[30:0];
    endtask

    task automatic drain();
        wait (pending_faces.size() == 0 && expected_fluxes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_faces.push_back(rand_face());
    endtask

    // ---------------- driver ----------------
    function automatic bit idle_now();
        // no idling in a long window inside the first random batch
        if (cycle_count > 150 && cycle_count < 400)
            return 1'b0;
        return $urandom_range(99) < 31;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_tvalid && !in_fire))
            begin
                if (pending_faces.size() != 0 && !idle_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_faces[0];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        flux_t want;
        flux_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_fluxes.size());
            $display("tb_shallow_water_hll_flux_core NOT OK");
            $finish;
        end
        in_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            expected_fluxes.push_back(hll_flux(face_t'(s_tdata), gravity_q));
            void'(pending_faces.pop_front());
            faces_sent++;
        end
        if (m_tvalid && m_tready)
        begin
            got.mass = m_tdata[31:0];
            got.normal_mom = m_tdata[63:32];
            got.tangent_mom = m_tdata[95:64];
            got.speed = m_tdata[126:96];
            got.sat = m_tuser;
            if (expected_fluxes.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_fluxes.pop_front();
                fluxes_checked++;
                if (got.mass !== want.mass)
                    $display("%0t: mass_flux exp %h act %h", $time, want.mass, got.mass);
                if (got.normal_mom !== want.normal_mom)
                    $display("%0t: normal_momentum_flux exp %h act %h", $time,
                             want.normal_mom, got.normal_mom);
                if (got.tangent_mom !== want.tangent_mom)
                    $display("%0t: tangent_momentum_flux exp %h act %h", $time,
                             want.tangent_mom, got.tangent_mom);
                if (got.speed !== want.speed)
                    $display("%0t: max_wave_speed exp %h act %h", $time, want.speed, got.speed);
                if (got.sat !== want.sat)
                    $display("%0t: saturated exp %b act %b", $time, want.sat, got.sat);
                if (got !== want)
                    errors++;
            end
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default gravity: directed corners
        pending_faces.push_back(make_face(0, 0, 0, 0, 0, 0));                 // both dry
        pending_faces.push_back(make_face(-65536, 5 << 16, 1, 32'h8000_0000, -3, 7));
        pending_faces.push_back(make_face(2 << 16, 20 << 16, 3 << 16,
                                          1 << 16, 18 << 16, -1 << 16));       // left upwind
        pending_faces.push_back(make_face(1 << 16, -20 << 16, 2 << 16,
                                          3 << 16, -19 << 16, 5 << 16));      // right upwind
        pending_faces.push_back(make_face(3 << 16, 1 << 16, -2 << 16,
                                          1 << 16, -1 << 16, 4 << 16));       // subcritical
        pending_faces.push_back(make_face(-2 << 16, 1 << 16, 1 << 16,
                                          2 << 16, 0, -1 << 16));             // negative depth
        pending_faces.push_back(make_face(2 << 16, 0, 0, -5 << 16, 1 << 16, 1 << 16));
        pending_faces.push_back(make_face(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_faces.push_back(make_face(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        pending_faces.push_back(make_face(1, 32'h8000_0000, 32'h7FFF_FFFF,
                                          1, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_faces.push_back(make_face(32'hFFFF_FFFF, -1, -1, 32'hFFFF_FFFF, -1, -1));
        pending_faces.push_back(make_face(1, 0, 0, 0, 0, 0));
        queue_random(300);
        drain();

        // zero gravity: still water gives zero wave speeds
        write_gravity(32'd0);
        pending_faces.push_back(make_face(2 << 16, 0, 3 << 16, 1 << 16, 0, -1 << 16));
        pending_faces.push_back(make_face(2 << 16, 1 << 16, 0, 1 << 16, -1 << 16, 0));
        pending_faces.push_back(make_face(2 << 16, 1 << 16, 0, 1 << 16, 2 << 16, 0));
        queue_random(150);
        drain();

        write_gravity(GRAV_MAX);
        pending_faces.push_back(make_face(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0));
        queue_random(150);
        drain();

        write_gravity(GRAV_ONE);
        queue_random(300);
        drain();

        $display("Covered %0d faces (%0d results checked) at gravity 9.81, 0, max and 1.0,",
                 faces_sent, fluxes_checked);
        $display("with dry, stagnant, upwind, blended and saturating faces under random stalls.");
        if (errors == 0 && expected_fluxes.size() == 0)
            $display("tb_shallow_water_hll_flux_core OK");
        else
            $display("tb_shallow_water_hll_flux_core NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/swhf_pkg.sv
rtl/swhf_cfg.sv
rtl/swhf_sqrt.sv
rtl/swhf_div.sv
rtl/shallow_water_hll_flux_core.sv
tb/sv/tb_shallow_water_hll_flux_core.sv
